// ===== hw/rtl/life_automaton_generation_macros.svh =====
// ----------------------------------------------------------------------------
// life automaton generation assertion macros
// concurrent checks on aclk, held off while aresetn is low; empty in synthesis
// ----------------------------------------------------------------------------
`ifndef LIFE_AUTOMATON_GENERATION_MACROS_SVH
`define LIFE_AUTOMATON_GENERATION_MACROS_SVH

`ifndef SYNTHESIS

// consequent must hold in the same cycle as the antecedent
`define LAG_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lag assertion failed");

// consequent must hold in the cycle after the antecedent
`define LAG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lag assertion failed");

`else

`define LAG_ASSERT_SAME(label, ante, cons)
`define LAG_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hw/rtl/lag_pkg.sv =====
// ----------------------------------------------------------------------------
// lag_pkg
// shared sizes, codes, queue entry type and the b3/s23 cell rule
// ----------------------------------------------------------------------------
package lag_pkg;

    // grid limits and field widths
    localparam int MAX_COLS   = 64;
    localparam int MAX_ROWS   = 1024;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int COLS_CFG_W = 7;
    localparam int ROWS_CFG_W = 11;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;

    localparam logic [COLS_CFG_W-1:0] GRID_COLS_RESET = COLS_CFG_W'(60);
    localparam logic [ROWS_CFG_W-1:0] GRID_ROWS_RESET = ROWS_CFG_W'(25);

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // neighbour counts of the rule
    localparam int BIRTH_COUNT   = 3;
    localparam int SURVIVE_COUNT = 2;

    // result jobs one item can complete, in output order
    localparam int JOBS = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_COLS = 1'b0,
        CFG_GRID_ROWS = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        JOB_UP_LEFT = 2'd0,   // cell (r-1, c-1)
        JOB_UP      = 2'd1,   // cell (r-1, c) on the last column
        JOB_LEFT    = 2'd2,   // cell (r, c-1) on the last row
        JOB_HERE    = 2'd3    // cell (r, c) at the frame's last cell
    } job_t;

    // one window column: bit 0 row r, bit 1 row r-1, bit 2 row r-2
    typedef logic [2:0] col_vec_t;

    // 3x3 window ending at the newest cell; cells outside the grid are zero
    typedef struct packed {
        col_vec_t col0;   // column c
        col_vec_t col1;   // column c-1
        col_vec_t col2;   // column c-2
    } window_t;

    typedef struct packed {
        window_t           win;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [JOBS-1:0]   jobs;
    } job_entry_t;

    // next state of the window cell at (row offset cr, col offset cc);
    // neighbours beyond the window lie past the grid's last row or column
    function automatic logic next_state(input window_t win, input logic cr, input logic cc);
        col_vec_t   grid [3];
        logic [3:0] count;
        logic       self_alive;
        grid[0]    = win.col0;
        grid[1]    = win.col1;
        grid[2]    = win.col2;
        count      = '0;
        self_alive = grid[{1'b0, cc}][{1'b0, cr}];
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                if ((r <= int'(cr) + 1) && (c <= int'(cc) + 1) &&
                    !((r == int'(cr)) && (c == int'(cc)))) begin
                    count = count + 4'(grid[c][r]);
                end
            end
        end
        if (count == 4'(BIRTH_COUNT)) begin
            return 1'b1;
        end else if (count == 4'(SURVIVE_COUNT)) begin
            return self_alive;
        end
        return 1'b0;
    endfunction

endpackage

// ===== hw/rtl/lag_front.sv =====
// ----------------------------------------------------------------------------
// lag_front
// raster position tracking, column line store, window build and job classing
// ----------------------------------------------------------------------------
module lag_front
    import lag_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_cell_alive,
    output logic                  q_push,
    output job_entry_t            q_entry,
    input  logic                  q_full
);

    logic [COLS_CFG_W-1:0] grid_cols_reg;
    logic [ROWS_CFG_W-1:0] grid_rows_reg;
    logic [ROW_W-1:0]      row_pos_reg, row_pos_next;
    logic [COL_W-1:0]      col_pos_reg, col_pos_next;
    logic [COL_W-1:0]      last_col;
    logic [ROW_W-1:0]      last_row;
    logic                  at_last_col, at_last_row;
    logic                  accept;
    logic [JOBS-1:0]       a_jobs;

    logic                  b_valid_reg, b_valid_next;
    logic                  b_cell_reg;
    logic [ROW_W-1:0]      b_row_reg;
    logic [COL_W-1:0]      b_col_reg;
    logic [JOBS-1:0]       b_jobs_reg;
    logic                  b_fire;

    // column store: bit 0 newest row at that column, bit 1 the row above
    logic [1:0]            col_mem [MAX_COLS];
    logic [1:0]            rd_data_reg;
    logic                  byp_hit_reg;
    logic [1:0]            byp_data_reg;
    logic [1:0]            above;
    logic [1:0]            wr_data;

    col_vec_t              cur_col;
    col_vec_t              win_col1_reg, win_col2_reg;
    logic                  row_ok1, row_ok2, col_ok1, col_ok2;

    // effective last row and column, out-of-range sizes clamped
    always_comb begin
        if (grid_cols_reg == '0) begin
            last_col = '0;
        end else if (grid_cols_reg > COLS_CFG_W'(MAX_COLS)) begin
            last_col = COL_W'(MAX_COLS - 1);
        end else begin
            last_col = COL_W'(grid_cols_reg - 1'b1);
        end
        if (grid_rows_reg == '0) begin
            last_row = '0;
        end else if (grid_rows_reg > ROWS_CFG_W'(MAX_ROWS)) begin
            last_row = ROW_W'(MAX_ROWS - 1);
        end else begin
            last_row = ROW_W'(grid_rows_reg - 1'b1);
        end
    end

    // stage a: accept and classify by raster position
    assign accept      = s_valid && s_ready;
    assign at_last_col = (col_pos_reg == last_col);
    assign at_last_row = (row_pos_reg == last_row);

    always_comb begin
        a_jobs              = '0;
        a_jobs[JOB_UP_LEFT] = (row_pos_reg != '0) && (col_pos_reg != '0);
        a_jobs[JOB_UP]      = (row_pos_reg != '0) && at_last_col;
        a_jobs[JOB_LEFT]    = at_last_row && (col_pos_reg != '0);
        a_jobs[JOB_HERE]    = at_last_row && at_last_col;
    end

    // raster counters wrap at the end of each row and frame
    always_comb begin
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        if (accept) begin
            if (at_last_col) begin
                col_pos_next = '0;
                row_pos_next = at_last_row ? '0 : row_pos_reg + 1'b1;
            end else begin
                col_pos_next = col_pos_reg + 1'b1;
            end
        end
    end

    // stage b: one item in flight, held while the queue is full and the item has jobs
    assign b_fire  = b_valid_reg && ((b_jobs_reg == '0) || !q_full);
    assign s_ready = !b_valid_reg || b_fire;

    always_comb begin
        b_valid_next = b_valid_reg;
        if (accept) begin
            b_valid_next = 1'b1;
        end else if (b_fire) begin
            b_valid_next = 1'b0;
        end
    end

    // edge masks, rows and columns outside the grid read as dead
    assign row_ok1 = (b_row_reg != '0);
    assign row_ok2 = (b_row_reg > ROW_W'(1));
    assign col_ok1 = (b_col_reg != '0);
    assign col_ok2 = (b_col_reg > COL_W'(1));

    assign above   = byp_hit_reg ? byp_data_reg : rd_data_reg;
    assign cur_col = {above[1] & row_ok2, above[0] & row_ok1, b_cell_reg};
    assign wr_data = cur_col[1:0];

    // queue entry
    assign q_push        = b_fire && (b_jobs_reg != '0);
    assign q_entry.win   = '{col0: cur_col,
                             col1: win_col1_reg & {3{col_ok1}},
                             col2: win_col2_reg & {3{col_ok2}}};
    assign q_entry.row   = b_row_reg;
    assign q_entry.col   = b_col_reg;
    assign q_entry.jobs  = b_jobs_reg;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_cols_reg <= GRID_COLS_RESET;
            grid_rows_reg <= GRID_ROWS_RESET;
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            b_valid_reg   <= 1'b0;
            byp_hit_reg   <= 1'b0;
        end else begin
            b_valid_reg <= b_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_idx_t'(cfg_wr_index))
                    CFG_GRID_COLS: grid_cols_reg <= cfg_wr_data[COLS_CFG_W-1:0];
                    CFG_GRID_ROWS: grid_rows_reg <= cfg_wr_data[ROWS_CFG_W-1:0];
                    default: ;
                endcase
                row_pos_reg <= '0;
                col_pos_reg <= '0;
            end else begin
                row_pos_reg <= row_pos_next;
                col_pos_reg <= col_pos_next;
            end
            if (accept) begin
                byp_hit_reg <= b_fire && (b_col_reg == col_pos_reg);
            end
        end
    end

    // stage b payload and window history
    always_ff @(posedge aclk) begin
        if (accept) begin
            b_cell_reg   <= s_cell_alive;
            b_row_reg    <= row_pos_reg;
            b_col_reg    <= col_pos_reg;
            b_jobs_reg   <= a_jobs;
            byp_data_reg <= wr_data;
        end
        if (b_fire) begin
            win_col1_reg <= cur_col;
            win_col2_reg <= win_col1_reg;
        end
    end

    // column store, read on accept, written back as the item leaves stage b
    always_ff @(posedge aclk) begin
        if (b_fire) begin
            col_mem[b_col_reg] <= wr_data;
        end
        if (accept) begin
            rd_data_reg <= col_mem[col_pos_reg];
        end
    end

endmodule

// ===== hw/rtl/lag_queue.sv =====
// ----------------------------------------------------------------------------
// lag_queue
// short first-in first-out queue of job entries between front and back
// ----------------------------------------------------------------------------
`include "life_automaton_generation_macros.svh"

module lag_queue
    import lag_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  job_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output logic       head_valid,
    output job_entry_t head
);

    job_entry_t          slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slots[rd_ptr_reg];

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    `LAG_ASSERT_SAME(a_no_overflow, push, !full)
    `LAG_ASSERT_SAME(a_no_underflow, pop, head_valid)
    `LAG_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

// ===== hw/rtl/lag_back.sv =====
// ----------------------------------------------------------------------------
// lag_back
// walks the jobs of the head entry, one result a cycle unless m_ready stalls, into the output register
// ----------------------------------------------------------------------------
`include "life_automaton_generation_macros.svh"

module lag_back
    import lag_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             head_valid,
    input  job_entry_t       head,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_next_alive,
    output logic [ROW_W-1:0] m_cell_row,
    output logic [COL_W-1:0] m_cell_col,
    output logic             m_last_of_run,
    output logic             m_frame_done
);

    logic [JOBS-1:0]  done_reg, done_next;
    logic [JOBS-1:0]  pending;
    logic [JOBS-1:0]  sel_bit;
    job_t             sel;
    logic             last_job;
    logic             issue;
    logic             cr, cc;

    logic             m_valid_reg, m_valid_next;
    logic             m_next_alive_reg;
    logic [ROW_W-1:0] m_cell_row_reg;
    logic [COL_W-1:0] m_cell_col_reg;
    logic             m_last_of_run_reg;
    logic             m_frame_done_reg;

    // next job of the head entry in output order
    assign pending = head.jobs & ~done_reg;

    always_comb begin
        priority if (pending[JOB_UP_LEFT]) begin
            sel = JOB_UP_LEFT;
        end else if (pending[JOB_UP]) begin
            sel = JOB_UP;
        end else if (pending[JOB_LEFT]) begin
            sel = JOB_LEFT;
        end else begin
            sel = JOB_HERE;
        end
    end

    assign sel_bit  = JOBS'(1) << sel;
    assign last_job = ((pending & ~sel_bit) == '0);
    assign issue    = head_valid && (!m_valid_reg || m_ready);
    assign pop      = issue && last_job;

    // center of the job inside the window
    assign cr = (sel == JOB_UP_LEFT) || (sel == JOB_UP);
    assign cc = (sel == JOB_UP_LEFT) || (sel == JOB_LEFT);

    always_comb begin
        done_next = done_reg;
        if (pop) begin
            done_next = '0;
        end else if (issue) begin
            done_next = done_reg | sel_bit;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (issue) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            done_reg    <= done_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (issue) begin
            m_next_alive_reg  <= next_state(head.win, cr, cc);
            m_cell_row_reg    <= head.row - ROW_W'(cr);
            m_cell_col_reg    <= head.col - COL_W'(cc);
            m_last_of_run_reg <= last_job;
            m_frame_done_reg  <= (sel == JOB_HERE);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_next_alive  = m_next_alive_reg;
    assign m_cell_row    = m_cell_row_reg;
    assign m_cell_col    = m_cell_col_reg;
    assign m_last_of_run = m_last_of_run_reg;
    assign m_frame_done  = m_frame_done_reg;

    `LAG_ASSERT_SAME(a_frame_done_ends_run, m_valid_reg && m_frame_done_reg, m_last_of_run_reg)
    `LAG_ASSERT_NEXT(a_run_continues, m_valid_reg && m_ready && !m_last_of_run_reg, m_valid_reg)
    `LAG_ASSERT_SAME(a_done_clear_idle, !head_valid, done_reg == '0)

endmodule

// ===== hw/rtl/life_automaton_generation.sv =====
// an accepted item passes the stage b register and a queue slot before its first result reaches m_valid
// throughput: one item per cycle into the front while the queue has room; the back gives
// one result per cycle unless m_ready stalls it; an item gives 0 to 4, 4 on the frame's last cell
// the 4-entry queue absorbs the 2-result items at row ends; along the last row an item before the
// last cell gives up to 2 results, so input there slows to the pace of the back's results
// reset: grid 60 x 25, raster position zero, no clearing pass of the column store
// ----------------------------------------------------------------------------
// life_automaton_generation
// streaming b3/s23 generation step over a raster cell stream with clipped edges
// ----------------------------------------------------------------------------
module life_automaton_generation
    import lag_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_cell_alive,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_next_alive,
    output logic [ROW_W-1:0]      m_cell_row,
    output logic [COL_W-1:0]      m_cell_col,
    output logic                  m_last_of_run,
    output logic                  m_frame_done
);

    logic       q_push;
    job_entry_t q_entry;
    logic       q_full;
    logic       q_pop;
    logic       q_head_valid;
    job_entry_t q_head;

    // front: position, line store, window and job classing
    lag_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cell_alive (s_cell_alive),
        .q_push       (q_push),
        .q_entry      (q_entry),
        .q_full       (q_full)
    );

    // queue between front and back
    lag_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    // back: rule evaluation and result output
    lag_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (q_head_valid),
        .head          (q_head),
        .pop           (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_next_alive  (m_next_alive),
        .m_cell_row    (m_cell_row),
        .m_cell_col    (m_cell_col),
        .m_last_of_run (m_last_of_run),
        .m_frame_done  (m_frame_done)
    );

endmodule

// ===== test/life_automaton_generation_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// life_automaton_generation_tb
// streams raster cells through the b3/s23 generation block under random
// valid/ready idling, predicts every next-generation result in order and
// compares each field; covers tiny, clipped, default and maximum grid sizes
// ----------------------------------------------------------------------------
module life_automaton_generation_tb;
    import lag_pkg::*;

    localparam int          CLK_PERIOD   = 12;
    localparam int          RESET_CYCLES = 8;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          RANDOM_ITEMS = 270;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    // one next-generation result of a cell
    typedef struct {
        bit              alive;
        bit [ROW_W-1:0]  row;
        bit [COL_W-1:0]  col;
        bit              run_end;
        bit              frame_end;
    } gen_result_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index  = CFG_GRID_COLS;
    logic [CFG_DATA_W-1:0] cfg_wr_data   = '0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic                  s_cell_alive  = 1'b0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic                  m_next_alive;
    logic [ROW_W-1:0]      m_cell_row;
    logic [COL_W-1:0]      m_cell_col;
    logic                  m_last_of_run;
    logic                  m_frame_done;

    // generation tracker: last three rows, raster position and grid size
    bit                    cell_grid [3][MAX_COLS];
    int unsigned           pos_row   = 0;
    int unsigned           pos_col   = 0;
    bit [COLS_CFG_W-1:0]   cols_reg  = GRID_COLS_RESET;
    bit [ROWS_CFG_W-1:0]   rows_reg  = GRID_ROWS_RESET;

    bit                    cell_feed [$];
    gen_result_t           gen_due   [$];

    int unsigned           mismatches  = 0;
    int unsigned           cycle_count = 0;
    bit                    in_fire     = 1'b0;
    int                    src_gap     = 0;
    int                    snk_gap     = 0;
    int                    src_idle_pct = 0;
    int                    snk_idle_pct = 0;
    bit                    calm        = 1'b0;

    life_automaton_generation u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cell_alive  (s_cell_alive),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_next_alive  (m_next_alive),
        .m_cell_row    (m_cell_row),
        .m_cell_col    (m_cell_col),
        .m_last_of_run (m_last_of_run),
        .m_frame_done  (m_frame_done)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // grid size as the block uses it: zero acts as one, clipped to the maximum
    function automatic int unsigned used_cols();
        if (cols_reg == 0) return 1;
        if (cols_reg > MAX_COLS) return MAX_COLS;
        return cols_reg;
    endfunction

    function automatic int unsigned used_rows();
        if (rows_reg == 0) return 1;
        if (rows_reg > MAX_ROWS) return MAX_ROWS;
        return rows_reg;
    endfunction

    // b3/s23 rule on the clipped 8-neighbourhood of (r, c)
    function automatic bit cell_next(int unsigned r, int unsigned c,
                                     int unsigned rows, int unsigned cols);
        int unsigned alive_count;
        int unsigned r_lo, r_hi, c_lo, c_hi;
        alive_count = 0;
        r_lo = (r == 0) ? 0 : r - 1;
        r_hi = (r + 1 < rows) ? r + 1 : r;
        c_lo = (c == 0) ? 0 : c - 1;
        c_hi = (c + 1 < cols) ? c + 1 : c;
        for (int unsigned p = r_lo; p <= r_hi; p++) begin
            for (int unsigned q = c_lo; q <= c_hi; q++) begin
                if (!(p == r && q == c)) begin
                    alive_count += cell_grid[p % 3][q];
                end
            end
        end
        if (alive_count == BIRTH_COUNT) return 1'b1;
        if (alive_count == SURVIVE_COUNT) return cell_grid[r % 3][c];
        return 1'b0;
    endfunction

    // store one cell and queue the results of every cell it completes
    function automatic void take_cell(bit alive);
        int unsigned rows, cols, cur_r, cur_c, n;
        int unsigned done_r [4];
        int unsigned done_c [4];
        gen_result_t res;
        cols = used_cols();
        rows = used_rows();
        n    = 0;
        if (pos_col >= cols || pos_row >= rows) begin
            pos_row = 0;
            pos_col = 0;
        end
        cur_r = pos_row;
        cur_c = pos_col;
        cell_grid[cur_r % 3][cur_c] = alive;

        if (cur_r >= 1 && cur_c >= 1) begin
            done_r[n] = cur_r - 1; done_c[n] = cur_c - 1; n++;
        end
        if (cur_r >= 1 && cur_c == cols - 1) begin
            done_r[n] = cur_r - 1; done_c[n] = cur_c; n++;
        end
        if (cur_r == rows - 1 && cur_c >= 1) begin
            done_r[n] = cur_r; done_c[n] = cur_c - 1; n++;
        end
        if (cur_r == rows - 1 && cur_c == cols - 1) begin
            done_r[n] = cur_r; done_c[n] = cur_c; n++;
        end

        for (int unsigned k = 0; k < n; k++) begin
            res.alive     = cell_next(done_r[k], done_c[k], rows, cols);
            res.row       = done_r[k][ROW_W-1:0];
            res.col       = done_c[k][COL_W-1:0];
            res.run_end   = (k + 1 == n);
            res.frame_end = (done_r[k] == rows - 1) && (done_c[k] == cols - 1);
            gen_due.push_back(res);
        end

        if (cur_c + 1 < cols) begin
            pos_col = cur_c + 1;
        end else begin
            pos_col = 0;
            pos_row = (cur_r + 1 < rows) ? cur_r + 1 : 0;
        end
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // cycle limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // accepted cells feed the tracker
    always @(posedge aclk) begin
        in_fire <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            take_cell(s_cell_alive);
        end
    end

    // cell driver with random idle bursts
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_valid <= 1'b0;
            end else if (cell_feed.size() > 0) begin
                s_cell_alive <= cell_feed.pop_front();
                s_valid      <= 1'b1;
                if ($urandom_range(99) < src_idle_pct) begin
                    src_gap <= $urandom_range(1, 10);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result sink with random stall bursts
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (snk_gap > 0) begin
            m_ready <= 1'b0;
            snk_gap <= snk_gap - 1;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(99) < snk_idle_pct) begin
                snk_gap <= $urandom_range(1, 10);
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin : result_check
        gen_result_t due;
        if (aresetn && m_valid && m_ready) begin
            if (gen_due.size() == 0) begin
                $error("result with nothing pending: row %0d col %0d",
                       m_cell_row, m_cell_col);
                mismatches++;
            end else begin
                due = gen_due.pop_front();
                check_field("next_alive", due.alive, m_next_alive);
                check_field("cell_row", due.row, m_cell_row);
                check_field("cell_col", due.col, m_cell_col);
                check_field("last_of_run", due.run_end, m_last_of_run);
                check_field("frame_done", due.frame_end, m_frame_done);
            end
        end
    end

    // register write; the tracker restarts its frame the same way
    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        if (idx == CFG_GRID_COLS) begin
            cols_reg = value[COLS_CFG_W-1:0];
        end else begin
            rows_reg = value[ROWS_CFG_W-1:0];
        end
        pos_row = 0;
        pos_col = 0;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_grid(int unsigned cols, int unsigned rows);
        write_reg(CFG_GRID_COLS, CFG_DATA_W'(cols));
        write_reg(CFG_GRID_ROWS, CFG_DATA_W'(rows));
    endtask

    // wait until every cell is taken and every result is back, then let
    // the pipeline drain cells that produced no result
    task automatic settle();
        while (cell_feed.size() != 0 || s_valid || gen_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic pick_idling();
        if (calm) begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
        end else begin
            src_idle_pct = $urandom_range(0, 3) * 15;
            snk_idle_pct = $urandom_range(0, 3) * 15;
        end
    endtask

    task automatic feed_bits(logic [15:0] bits, int n);
        for (int i = 0; i < n; i++) begin
            cell_feed.push_back(bits[i]);
        end
        settle();
    endtask

    task automatic feed_random(int n);
        int density;
        density = $urandom_range(15, 70);
        pick_idling();
        for (int i = 0; i < n; i++) begin
            cell_feed.push_back($urandom_range(99) < density);
        end
        settle();
    endtask

    // stimulus
    initial begin : stimulus
        int fed, n, gc, gr;
        fed = 0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // reset grid 60 x 25: first row and the start of the second
        feed_random(70);
        fed += 70;

        // single-cell grid, every item is a whole frame
        src_idle_pct = 20;
        snk_idle_pct = 20;
        set_grid(1, 1);
        feed_bits(16'h0005, 3);
        // 2 x 2 grid: three live cells, then a full grid, both leave every cell alive
        set_grid(2, 2);
        feed_bits(16'h00F7, 8);
        // 3 x 3 blinker turns from vertical to horizontal
        set_grid(3, 3);
        feed_bits(16'h0092, 9);
        // zero sizes act as one
        set_grid(0, 0);
        feed_bits(16'h0002, 2);

        // maximum grid, then sizes beyond it that clip to the maximum
        set_grid(MAX_COLS, MAX_ROWS);
        feed_random(100);
        fed += 100;
        set_grid(127, 2047);
        feed_random(70);
        fed += 70;

        // small grids with whole frames, partial frames and wraps
        while (fed < RANDOM_ITEMS) begin
            if (fed >= RANDOM_ITEMS - 40) calm = 1'b1;
            if ($urandom_range(0, 4) == 0) begin
                gc = $urandom_range(1, MAX_COLS);
                gr = $urandom_range(1, 2);
            end else begin
                gc = $urandom_range(1, 8);
                gr = $urandom_range(1, 6);
            end
            set_grid(gc, gr);
            n = gc * gr * $urandom_range(1, 2) + $urandom_range(0, 3);
            if (n > 48) n = 48;
            feed_random(n);
            fed += n;
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (gen_due.size() != 0) begin
            $error("%0d results never arrived", gen_due.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
